>>> hw/rtl/hdp_pkg.sv
// Types, name tables and per-byte step functions shared by the date header parser.
package hdp_pkg;

	// Result beat layout, lowest bit first.
	localparam int OUT_FIELDS_W = 51;
	localparam int OUT_W        = 56;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 5;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_EN = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SUMMER   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WINTER   = 2'd2;

	// Character codes used by the grammar.
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Months April to October take the summer offset.
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_OCT = 4'd10;

	// Parser phase, one-hot.
	typedef enum logic [10:0] {
		PH_WDAY   = 11'b000_0000_0001,
		PH_COMMA  = 11'b000_0000_0010,
		PH_DAY    = 11'b000_0000_0100,
		PH_MONTH  = 11'b000_0000_1000,
		PH_YEAR   = 11'b000_0001_0000,
		PH_HOUR   = 11'b000_0010_0000,
		PH_COLON1 = 11'b000_0100_0000,
		PH_MINUTE = 11'b000_1000_0000,
		PH_COLON2 = 11'b001_0000_0000,
		PH_SECOND = 11'b010_0000_0000,
		PH_DONE   = 11'b100_0000_0000
	} phase_t;

	// Complete parser state.
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  cnt;
		logic [23:0] wchars;
		logic [23:0] mchars;
		logic [13:0] acc;
		logic [6:0]  day;
		logic [13:0] year;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  sec_v;
		logic        mis;
	} st_t;

	// Outcome of offering one byte to the current phase.
	typedef struct packed {
		st_t  st;
		logic pass;
	} step_t;

	// Outcome of a name lookup.
	typedef struct packed {
		logic       found;
		logic [3:0] idx;
	} name_t;

	localparam st_t ST_RESET = '{
		phase: PH_WDAY, cnt: 3'd0, wchars: 24'd0, mchars: 24'd0, acc: 14'd0,
		day: 7'd0, year: 14'd0, hour: 7'd0, minute: 7'd0, sec_v: 7'd0, mis: 1'b0
	};

	localparam logic [23:0] MONTH_NAMES [12] = '{
		24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
		24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
	};

	localparam logic [23:0] DAY_NAMES [7] = '{
		24'h4D6F6E, 24'h547565, 24'h576564, 24'h546875, 24'h467269, 24'h536174,
		24'h53756E
	};

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic phase_t next_ph(phase_t p);
		phase_t n;
		unique case (p)
			PH_WDAY:   n = PH_COMMA;
			PH_COMMA:  n = PH_DAY;
			PH_DAY:    n = PH_MONTH;
			PH_MONTH:  n = PH_YEAR;
			PH_YEAR:   n = PH_HOUR;
			PH_HOUR:   n = PH_COLON1;
			PH_COLON1: n = PH_MINUTE;
			PH_MINUTE: n = PH_COLON2;
			PH_COLON2: n = PH_SECOND;
			default:   n = PH_DONE;
		endcase
		return n;
	endfunction

	// Store the accumulated number in the field of the current phase and move on.
	function automatic st_t finish_num(st_t s);
		st_t r;
		r = s;
		unique case (s.phase)
			PH_DAY:    r.day    = s.acc[6:0];
			PH_YEAR:   r.year   = s.acc;
			PH_HOUR:   r.hour   = s.acc[6:0];
			PH_MINUTE: r.minute = s.acc[6:0];
			default:   r.sec_v  = s.acc[6:0];
		endcase
		r.phase = next_ph(s.phase);
		r.cnt   = 3'd0;
		r.acc   = 14'd0;
		return r;
	endfunction

	// Offer one byte to the current phase; pass is set when the next phase must see it too.
	function automatic step_t take_step(st_t s, logic [7:0] c);
		step_t      r;
		logic [2:0] cnt_n;
		logic [2:0] maxd;
		logic       digit;
		r.st   = s;
		r.pass = 1'b0;
		cnt_n  = 3'(s.cnt + 3'd1);
		maxd   = (s.phase == PH_YEAR) ? 3'd4 : 3'd2;
		digit  = (c >= CH_ZERO) && (c <= CH_NINE);
		unique case (s.phase)
			PH_WDAY, PH_MONTH: begin
				if (is_space(c) || c == CH_NUL) begin
					if (s.cnt == 3'd0) begin
						if (c == CH_NUL)
							r.st.mis = 1'b1;
					end else begin
						r.st.phase = next_ph(s.phase);
						r.st.cnt   = 3'd0;
						r.pass     = 1'b1;
					end
				end else begin
					if (s.phase == PH_WDAY)
						r.st.wchars = {s.wchars[15:0], c};
					else
						r.st.mchars = {s.mchars[15:0], c};
					r.st.cnt = cnt_n;
					if (cnt_n >= 3'd3) begin
						r.st.phase = next_ph(s.phase);
						r.st.cnt   = 3'd0;
					end
				end
			end
			PH_COMMA, PH_COLON1, PH_COLON2: begin
				if (c == ((s.phase == PH_COMMA) ? CH_COMMA : CH_COLON))
					r.st.phase = next_ph(s.phase);
				else
					r.st.mis = 1'b1;
			end
			PH_DAY, PH_YEAR, PH_HOUR, PH_MINUTE, PH_SECOND: begin
				if (digit) begin
					r.st.acc = (s.acc << 3) + (s.acc << 1) + {10'd0, c[3:0]};
					r.st.cnt = cnt_n;
					if (cnt_n >= maxd)
						r.st = finish_num(r.st);
				end else if (s.cnt == 3'd0) begin
					if (!is_space(c))
						r.st.mis = 1'b1;
				end else begin
					r.st   = finish_num(s);
					r.pass = 1'b1;
				end
			end
			PH_DONE: begin
				r.st = s;
			end
			default: begin
				r.st.mis = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Month lookup: index 1 to 12.
	function automatic name_t month_lookup(logic [23:0] m);
		name_t r;
		r = '{found: 1'b0, idx: 4'd0};
		for (int i = 0; i < 12; i++) begin
			if (MONTH_NAMES[i] == m) begin
				r.found = 1'b1;
				r.idx   = 4'(i + 1);
			end
		end
		return r;
	endfunction

	// Weekday lookup: index 0 (Monday) to 6 (Sunday).
	function automatic name_t wday_lookup(logic [23:0] w);
		name_t r;
		r = '{found: 1'b0, idx: 4'd0};
		for (int i = 0; i < 7; i++) begin
			if (DAY_NAMES[i] == w) begin
				r.found = 1'b1;
				r.idx   = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/http_date_header_parser_core.sv
// Top level of the HTTP date header parser: byte stream in, one decoded date beat per header.
// Result path: a tlast beat goes through the input register, then loads the result register
// once the result slot is free.
// Throughput: one character beat per cycle while no result is waiting. A waiting result holds
// a tlast beat in the input register, which then stalls the input until the result is taken.
// Reset: parser state returns to the weekday token, valid and config registers to reset values.
module http_date_header_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Slave side: tdata = char_byte[7:0]; tlast = last_char.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           s_tlast,
	// Master side: tdata = parse_ok, weekday[3], day_of_month[7], month_number[4],
	// year_value[14], hour_value[8], minute_value[7], second_value[7], zero pad.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hdp_pkg::OUT_W-1:0]      m_tdata,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [hdp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [hdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hdp_pkg::*;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	st_t                     st_q;
	logic                    out_valid_q;
	logic [OUT_FIELDS_W-1:0] out_data_q;
	logic                    local_en_q;
	logic [4:0]              summer_q;
	logic [4:0]              winter_q;

	logic                    out_free;
	logic                    adv;
	step_t                   step1;
	step_t                   step2;
	st_t                     st_step;
	st_t                     st_fin;
	name_t                   mon;
	name_t                   wd;
	logic                    ok;
	logic [7:0]              hour_out;
	logic [4:0]              offset;
	logic [OUT_FIELDS_W-1:0] result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_en_q <= 1'b0;
			summer_q   <= 5'd2;
			winter_q   <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LOCAL_EN: local_en_q <= cfg_wdata[0];
				REG_SUMMER:   summer_q   <= cfg_wdata;
				REG_WINTER:   winter_q   <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// Handshake: a character beat always moves on, a tlast beat waits for a free result slot.
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// One byte may be seen by two phases in turn when it ends a token or number.
	always_comb begin
		step1   = take_step(st_q, byte_s1);
		step2   = take_step(step1.st, byte_s1);
		st_step = st_q;
		if (!st_q.mis) begin
			st_step = step1.st;
			if (step1.pass && !step1.st.mis)
				st_step = step2.st;
		end
	end

	// End of header: close a pending second, then look up names and build the result.
	always_comb begin
		st_fin = st_step;
		if (!st_step.mis && st_step.phase == PH_SECOND && st_step.cnt != 3'd0)
			st_fin = finish_num(st_step);
		mon    = month_lookup(st_fin.mchars);
		wd     = wday_lookup(st_fin.wchars);
		ok     = !st_fin.mis && st_fin.phase == PH_DONE && mon.found && wd.found;
		offset = (mon.idx >= MONTH_APR && mon.idx <= MONTH_OCT) ? summer_q : winter_q;
		hour_out = {1'b0, st_fin.hour};
		if (local_en_q)
			hour_out = {1'b0, st_fin.hour} + {3'd0, offset};
		if (ok)
			result = {st_fin.sec_v, st_fin.minute, hour_out, st_fin.year,
				mon.idx, st_fin.day, wd.idx[2:0], 1'b1};
		else
			result = '0;
	end

	// Parser state: restarts after every header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (adv) begin
			if (last_s1)
				st_q <= ST_RESET;
			else
				st_q <= st_step;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			out_data_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_FIELDS_W){1'b0}}, out_data_q};

	// A good parse always carries a known month and weekday.
	a_ok_names: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
			m_tdata[14:11] >= 4'd1 && m_tdata[14:11] <= 4'd12 && m_tdata[3:1] <= 3'd6)
		else $error("good parse with an unknown month or weekday");

	// A failed parse reports all fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_FIELDS_W-1:1] == '0)
		else $error("failed parse carries non-zero fields");

	// The parser restarts after the header end.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.phase == PH_WDAY && !st_q.mis && st_q.cnt == 3'd0)
		else $error("parser did not restart after the header end");

	// A header end held back by a waiting result stays in the input register.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !out_free |=> valid_s1 && last_s1 && $stable(byte_s1))
		else $error("stalled header end was lost");

	// A result is produced only from a header end.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result beat without a header end");

endmodule
